// ===== rtl/core/sshash_pkg.sv =====
package sshash_pkg;

   typedef logic [7:0]  char_type;
   typedef logic [31:0] word_type;

   // accumulator start values
   localparam word_type AccOneStart = 32'h0000_3b00;
   localparam word_type AccTwoStart = 32'h0000_0000;

   // end-of-string marker
   localparam char_type CharTerm = 8'h00;

   // xor/add/rotate mixing of both accumulators into the final hash
   function automatic word_type finish_hash(input word_type acc_a, input word_type acc_b);
      word_type a;
      word_type b;
      a = acc_a;
      b = acc_b;
      a = a ^ b;
      a = a + {b[17:0], b[31:18]};
      b = b ^ a;
      b = b + {a[5:0], a[31:6]};
      a = a ^ b;
      a = a + {b[26:0], b[31:27]};
      b = b ^ a;
      b = b + {a[7:0], a[31:8]};
      return b;
   endfunction

endpackage

// ===== rtl/core/small_string_hash.sv =====
// small_string_hash: streaming 32-bit hash of zero-terminated byte strings
//
// req channel: one string byte per beat on req_char_byte. A nonzero byte is
// folded into two 32-bit accumulators and gives no response; a zero byte
// ends the string and yields one beat on the rsp channel with the finished
// hash, after which the accumulators restart for the next string.
//
// throughput: one byte per cycle unless req_stall is high; the accumulator
// update is a handful of constant shift-adds between the input register and
// the accumulator registers. a terminator passes from the input register to
// the result register, which drives rsp_hash_value with rsp_valid high.
//
// when the rsp side stalls, nonzero bytes still drain through; only a
// terminator waiting for the occupied result register holds the input
// register, and req_stall rises in that case.
//
// reset (synchronous, active high) empties both registers and loads the
// accumulator start values, so the first string begins clean.
module small_string_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sshash_pkg::char_type  req_char_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sshash_pkg::word_type  rsp_hash_value
);
   import sshash_pkg::*;

   logic     in_valid_ff, in_valid_in;
   char_type in_byte_ff,  in_byte_in;
   word_type acc_one_ff,  acc_one_in;
   word_type acc_two_ff,  acc_two_in;
   logic     out_valid_ff, out_valid_in;
   word_type out_hash_ff,  out_hash_in;

   logic     out_free;
   logic     in_is_term;
   logic     in_done;
   logic     req_take;
   word_type sum_one;
   word_type mul_one;
   word_type sum_two;
   word_type rot_two;

   // held beat state
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign in_is_term = (in_byte_ff == CharTerm);
   assign in_done    = in_valid_ff && (!in_is_term || out_free);
   assign req_stall  = in_valid_ff && !in_done;
   assign req_take   = req_valid && !req_stall;

   // accumulator update: x9 and x5 as shift-adds
   assign sum_one = acc_one_ff + {24'd0, in_byte_ff};
   assign mul_one = sum_one + {sum_one[28:0], 3'b000};
   assign sum_two = acc_two_ff + mul_one;
   assign rot_two = {sum_two[24:0], sum_two[31:25]};

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (in_done ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_char_byte : in_byte_ff;
      acc_one_in   = acc_one_ff;
      acc_two_in   = acc_two_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_hash_in  = out_hash_ff;
      if (in_done) begin
         if (in_is_term) begin
            out_valid_in = 1'b1;
            out_hash_in  = finish_hash(acc_one_ff, acc_two_ff);
            acc_one_in   = AccOneStart;
            acc_two_in   = AccTwoStart;
         end else begin
            acc_one_in = mul_one;
            acc_two_in = rot_two + {rot_two[29:0], 2'b00};
         end
      end
   end

   // control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_one_ff   <= AccOneStart;
         acc_two_ff   <= AccTwoStart;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_one_ff   <= acc_one_in;
         acc_two_ff   <= acc_two_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_hash_ff <= out_hash_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

`ifndef SYNTHESIS
   // a finished terminator always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      (in_done && in_is_term) |=> out_valid_ff)
      else $error("terminator beat lost");

   // accumulators restart after every terminator
   assert property (@(posedge clock) disable iff (reset)
      (in_done && in_is_term) |=> (acc_one_ff == AccOneStart && acc_two_ff == AccTwoStart))
      else $error("accumulators not restarted");

   // input only backs up behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_is_term))
      else $error("spurious req_stall");
`endif

endmodule

// ===== tb/small_string_hash_checker.sv =====
`timescale 1ns / 1ps

// watches both channels of small_string_hash, predicts each hash and checks it
module small_string_hash_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  sshash_pkg::char_type  req_char_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sshash_pkg::word_type  rsp_hash_value,
   output int                    fail_count,
   output int                    pending_count,
   output int                    hash_count
);
   import sshash_pkg::*;

   localparam int       MaxReports = 10;
   localparam word_type MulOne     = 32'd9;
   localparam word_type MulTwo     = 32'd5;

   // predicted accumulators and hashes still owed by the block
   word_type acc_one;
   word_type acc_two;
   word_type owed_hashes[$];

   function automatic word_type rol(input word_type x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic word_type ror(input word_type x, input int unsigned r);
      return (x >> r) | (x << (32 - r));
   endfunction

   // xor/add/rotate mixing of the two accumulators
   function automatic word_type mixed_hash(input word_type a, input word_type b);
      a = a ^ b;
      a = a + rol(b, 14);
      b = b ^ a;
      b = b + ror(a, 6);
      a = a ^ b;
      a = a + rol(b, 5);
      b = b ^ a;
      b = b + ror(a, 8);
      return b;
   endfunction

   task automatic log_failure(input string what);
      if (fail_count < MaxReports) begin
         $display("%0t: mismatch: %s", $realtime, what);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      word_type expected;
      if (reset) begin
         acc_one = AccOneStart;
         acc_two = AccTwoStart;
         owed_hashes.delete();
         fail_count    = 0;
         pending_count = 0;
         hash_count    = 0;
      end else begin
         // result beat: compare against the oldest owed hash
         if (rsp_valid && !rsp_stall) begin
            if (owed_hashes.size() == 0) begin
               log_failure($sformatf("hash %08h with none expected", rsp_hash_value));
            end else begin
               expected = owed_hashes.pop_front();
               hash_count++;
               if (rsp_hash_value !== expected) begin
                  log_failure($sformatf("hash_value expected %08h actual %08h",
                                        expected, rsp_hash_value));
               end
            end
         end
         // input beat: fold a byte or finish the string
         if (req_valid && !req_stall) begin
            if (req_char_byte == CharTerm) begin
               owed_hashes.push_back(mixed_hash(acc_one, acc_two));
               acc_one = AccOneStart;
               acc_two = AccTwoStart;
            end else begin
               acc_one = (acc_one + word_type'(req_char_byte)) * MulOne;
               acc_two = rol(acc_two + acc_one, 7) * MulTwo;
            end
         end
         pending_count = owed_hashes.size();
      end
   end

endmodule

// ===== tb/tb_small_string_hash.sv =====
`timescale 1ns / 1ps

module tb_small_string_hash;
   import sshash_pkg::*;

   localparam int ByteTarget  = 850;
   localparam int DrainCycles = 10;

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   char_type req_char_byte = '0;
   logic     rsp_stall     = 1'b0;
   logic     req_stall;
   logic     rsp_valid;
   word_type rsp_hash_value;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int byte_total      = 0;
   int string_total    = 0;
   int fail_count;
   int pending_count;
   int hash_count;

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   small_string_hash DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_byte  (req_char_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   small_string_hash_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_byte  (req_char_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .hash_count     (hash_count)
   );

   // random back-pressure on the hash output
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one input beat, after a random idle gap
   task automatic send_byte(input char_type b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_total++;
      if (b == CharTerm) string_total++;
   endtask

   // string of nonzero bytes (all ff, printable, 1 to 3, or any) followed by the terminator
   task automatic send_string(input int len, input int flavor);
      char_type b;
      for (int i = 0; i < len; i++) begin
         case (flavor)
            0: begin
               b = 8'hff;
            end
            1: begin
               b = char_type'($urandom_range(126, 32));
            end
            2: begin
               b = char_type'($urandom_range(3, 1));
            end
            default: begin
               b = char_type'($urandom_range(255, 1));
            end
         endcase
         send_byte(b);
      end
      send_byte(CharTerm);
   endtask

   initial begin
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty strings back to back, single extreme bytes, bit patterns, an all-ff string, "abc"
      send_byte(CharTerm);
      send_byte(CharTerm);
      send_byte(8'h01);
      send_byte(CharTerm);
      send_byte(8'hff);
      send_byte(CharTerm);
      send_byte(8'h80);
      send_byte(CharTerm);
      send_byte(8'h55);
      send_byte(8'haa);
      send_byte(CharTerm);
      send_byte(8'h7f);
      send_byte(CharTerm);
      send_string(8, 0);
      send_byte("a");
      send_byte("b");
      send_byte("c");
      send_byte(CharTerm);

      // random strings across four idle/stall mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
            1: begin
               sender_idle_pct = 46;
               stall_pct       = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct       = 46;
            end
            default: begin
               sender_idle_pct = 28;
               stall_pct       = 28;
            end
         endcase
         while (byte_total < ByteTarget * (phase + 1) / 4) begin
            if ($urandom_range(15) == 0) len = $urandom_range(64, 13);
            else len = $urandom_range(12, 0);
            send_string(len, $urandom_range(5));
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("summary: %0d bytes in %0d strings over four idle/stall mixes, %0d hashes checked",
               byte_total, string_total, hash_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (pending_count != 0) $display("%0d hashes never arrived", pending_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout: run did not finish");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sshash_pkg.sv
rtl/core/small_string_hash.sv
tb/small_string_hash_checker.sv
tb/tb_small_string_hash.sv
